/* rtl/plam_pkg.sv */
package plam_pkg;

  localparam logic [1:0] KIND_QUERY  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_LIMITS = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [2:0] ST_MAPPED   = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_UNLOADED = 3'd2;
  localparam logic [2:0] ST_PIN_MAX  = 3'd3;
  localparam logic [2:0] ST_PIN_MIN  = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;
  localparam logic [2:0] ST_DUP      = 3'd6;
  localparam logic [2:0] ST_FULL     = 3'd7;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         axis;
    logic signed [31:0] design_value;
    logic signed [31:0] user_value;
    logic signed [31:0] limit_min;
    logic signed [31:0] limit_max;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
  } out_beat_t;

endpackage

/* rtl/plam_ram.sv */
module plam_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/piecewise_linear_axis_map.sv */
// Limits, clear and passthrough beats go straight from accept to the result.
// Query: scans breakpoints (read, compare), and when it interpolates adds
//   32 multiply steps, 65 divide steps and a rounding step.
// Insert: scans keys (read, compare), shifts entries up (read, write), then writes the new entry.
// Throughput: one beat in flight; input stalled from accept until the result is
//   loaded. rst (sync) clears counts, limits, map_enable.
module piecewise_linear_axis_map #(
  parameter int AXES   = 4,
  parameter int POINTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               map_enable_we,
  input  logic               map_enable_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  plam_pkg::in_beat_t in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output plam_pkg::out_beat_t out_item
);

  localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int CW  = $clog2(POINTS + 1);
  localparam int ADW = $clog2(AXES * POINTS);
  localparam logic [ADW-1:0] PTS = ADW'(POINTS);
  localparam logic [CW-1:0]  PMAX = CW'(POINTS);

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCMP, S_SHR, S_SHW, S_INS, S_MUL, S_DIV, S_RND, S_FIN
  } state_t;

  state_t state;

  // per-axis state
  logic               map_en;
  logic [CW-1:0]      bcount [AXES];
  logic signed [31:0] axis_low [AXES];
  logic signed [31:0] axis_high [AXES];

  // working registers
  logic [AXW-1:0]     ax;
  logic [1:0]         kind;
  logic signed [31:0] dv, uv, lou, res;
  logic [2:0]         st;
  logic [CW-1:0]      idx, k, n;
  logic [63:0]        prev;
  logic               neg;
  logic [32:0]        mcand;
  logic [65:0]        acc;      // product, then dividend/quotient
  logic [31:0]        den, rem;
  logic [6:0]         cnt;

  // breakpoint RAM: {design, user}
  logic           ram_we;
  logic [ADW-1:0] ram_waddr, ram_raddr, base;
  logic [63:0]    ram_wdata, rd_data;
  logic [CW-1:0]  k_dec;

  plam_ram #(.WIDTH(64), .DEPTH(AXES * POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign base  = ADW'(ax) * PTS;
  assign k_dec = k - 1'b1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = base + ADW'(idx);
    ram_wdata = {dv, uv};
    ram_raddr = base + ADW'(idx);
    case (state)
      S_SHR: ram_raddr = base + ADW'(k_dec);
      S_SHW: begin
        ram_we    = 1'b1;
        ram_waddr = base + ADW'(k);
        ram_wdata = rd_data;
      end
      S_INS: ram_we = 1'b1;
      default: ;
    endcase
  end

  // accept decode
  logic          acc_in, ax_ok;
  logic [CW-1:0] n_in;
  assign in_stall = (state != S_IDLE);
  assign acc_in   = in_valid && !in_stall;
  assign ax_ok    = (32'(in_item.axis) < AXES);
  assign n_in     = ax_ok ? bcount[AXW'(in_item.axis)] : '0;

  // first result and next state picked at accept
  logic signed [31:0] res_in;
  logic [2:0]         st_in;
  state_t             state_in;
  always_comb begin
    res_in   = '0;
    st_in    = plam_pkg::ST_DONE;
    state_in = S_FIN;
    case (in_item.kind)
      plam_pkg::KIND_QUERY: begin
        if (!map_en) begin
          res_in = in_item.design_value;
          st_in  = plam_pkg::ST_UNLOADED;
        end else if (n_in == '0) begin
          res_in = in_item.design_value;
          st_in  = plam_pkg::ST_EMPTY;
        end else begin
          state_in = S_SRD;
        end
      end
      plam_pkg::KIND_INSERT: begin
        if (ax_ok) begin
          state_in = (n_in == '0) ? S_INS : S_SRD;
        end
      end
      default: ;
    endcase
  end

  // scan compare and interpolation setup
  logic signed [31:0] d_cur, u_cur, d_prev, u_prev;
  logic               less, eq, last;
  logic signed [32:0] du, dd, dden;
  logic [CW-1:0]      idx_inc;
  assign d_cur   = rd_data[63:32];
  assign u_cur   = rd_data[31:0];
  assign d_prev  = prev[63:32];
  assign u_prev  = prev[31:0];
  assign less    = d_cur < dv;
  assign eq      = d_cur == dv;
  assign idx_inc = idx + 1'b1;
  assign last    = (idx_inc == n);
  assign du      = {u_cur[31], u_cur} - {u_prev[31], u_prev};
  assign dd      = {dv[31], dv} - {d_prev[31], d_prev};
  assign dden    = {d_cur[31], d_cur} - {d_prev[31], d_prev};

  // shift-add multiply and shift-subtract divide on a shared accumulator
  logic [34:0] mul_sum;
  logic [32:0] rs;
  logic        ge;
  logic [33:0] qr, sres;
  logic        up;
  assign mul_sum = {1'b0, acc[65:32]} + 35'(mcand);
  assign rs      = {rem, acc[64]};
  assign ge      = rs >= {1'b0, den};
  assign up      = {rem, 1'b0} >= {1'b0, den};
  assign qr      = 34'(acc[32:0]) + 34'(up);
  assign sres    = neg ? ({lou[31], lou[31], lou} - qr) : ({lou[31], lou[31], lou} + qr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      map_en    <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        bcount[a]    <= '0;
        axis_low[a]  <= '0;
        axis_high[a] <= '0;
      end
    end else begin
      if (map_enable_we) begin
        map_en <= map_enable_wdata;
      end
      // output register: load the finished beat once the old one is gone
      if (state == S_FIN && (!out_valid || !out_stall)) begin
        out_valid             <= 1'b1;
        out_item.result_value <= res;
        out_item.status       <= st;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc_in) begin
            ax    <= AXW'(in_item.axis);
            kind  <= in_item.kind;
            dv    <= in_item.design_value;
            uv    <= in_item.user_value;
            idx   <= '0;
            k     <= n_in;
            n     <= n_in;
            res   <= res_in;
            st    <= st_in;
            state <= state_in;
            case (in_item.kind)
              plam_pkg::KIND_LIMITS: begin
                if (ax_ok) begin
                  axis_low[AXW'(in_item.axis)]  <= in_item.limit_min;
                  axis_high[AXW'(in_item.axis)] <= in_item.limit_max;
                end
              end
              plam_pkg::KIND_CLEAR: begin
                if (ax_ok) begin
                  bcount[AXW'(in_item.axis)] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          if (kind == plam_pkg::KIND_QUERY) begin
            if (less) begin
              if (last) begin
                res   <= axis_high[ax];
                st    <= plam_pkg::ST_PIN_MAX;
                state <= S_FIN;
              end else begin
                prev  <= rd_data;
                idx   <= idx_inc;
                state <= S_SRD;
              end
            end else if (eq) begin
              res   <= u_cur;
              st    <= plam_pkg::ST_MAPPED;
              state <= S_FIN;
            end else if (idx == '0) begin
              res   <= axis_low[ax];
              st    <= plam_pkg::ST_PIN_MIN;
              state <= S_FIN;
            end else begin
              neg   <= du[32];
              mcand <= du[32] ? 33'(-du) : 33'(du);
              acc   <= {34'd0, dd[31:0]};
              den   <= dden[31:0];
              lou   <= u_prev;
              cnt   <= 7'd32;
              state <= S_MUL;
            end
          end else begin
            // insert
            if (less && !last) begin
              idx   <= idx_inc;
              state <= S_SRD;
            end else if (eq) begin
              st    <= plam_pkg::ST_DUP;
              state <= S_FIN;
            end else if (n >= PMAX) begin
              st    <= plam_pkg::ST_FULL;
              state <= S_FIN;
            end else if (less) begin
              idx   <= n;
              state <= S_INS;
            end else begin
              state <= (k == idx) ? S_INS : S_SHR;
            end
          end
        end
        S_SHR: state <= S_SHW;
        S_SHW: begin
          k     <= k_dec;
          state <= (k_dec == idx) ? S_INS : S_SHR;
        end
        S_INS: begin
          bcount[ax] <= n + 1'b1;
          st         <= plam_pkg::ST_DONE;
          state      <= S_FIN;
        end
        S_MUL: begin
          acc <= acc[0] ? {mul_sum, acc[31:1]} : {1'b0, acc[65:1]};
          if (cnt == 7'd1) begin
            rem   <= '0;
            cnt   <= 7'd65;
            state <= S_DIV;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DIV: begin
          rem        <= ge ? 32'(rs - {1'b0, den}) : rs[31:0];
          acc[64:0]  <= {acc[63:0], ge};
          cnt        <= cnt - 1'b1;
          if (cnt == 7'd1) begin
            state <= S_RND;
          end
        end
        S_RND: begin
          res   <= sres[31:0];
          st    <= plam_pkg::ST_MAPPED;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/plam_checker.sv */
module plam_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input plam_pkg::out_beat_t out_item
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output beat changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == plam_pkg::ST_DONE ||
                  out_item.status == plam_pkg::ST_DUP ||
                  out_item.status == plam_pkg::ST_FULL)
    |-> out_item.result_value == 32'sd0)
    else $error("nonzero result on command beat");

endmodule

bind piecewise_linear_axis_map plam_checker u_plam_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int AXES        = 4;
  localparam int POINTS      = 16;
  localparam int RAND_ITEMS  = 1550;
  localparam int STALL_LIMIT = 5000;  // cycles without any accepted beat

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                map_enable_we = 1'b0;
  logic                map_enable_wdata = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  plam_pkg::in_beat_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  plam_pkg::out_beat_t out_item;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  piecewise_linear_axis_map #(.AXES(AXES), .POINTS(POINTS)) dut (
    .clk(clk),
    .rst(rst),
    .map_enable_we(map_enable_we),
    .map_enable_wdata(map_enable_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  // ---------------------------------------------------------------------
  // Predictor state: breakpoint tables, counts, limits and the map enable
  // ---------------------------------------------------------------------
  logic signed [31:0] key_tab  [AXES][POINTS];
  logic signed [31:0] user_tab [AXES][POINTS];
  int                 key_cnt  [AXES];
  logic signed [31:0] lim_lo   [AXES];
  logic signed [31:0] lim_hi   [AXES];
  logic               map_on;

  plam_pkg::out_beat_t pending_results[$];
  int                  errors = 0;

  // Exact interpolation with rounding half away from zero.
  function automatic logic signed [31:0] lerp(input logic signed [31:0] v,
      input logic signed [31:0] lo_d, input logic signed [31:0] lo_u,
      input logic signed [31:0] hi_d, input logic signed [31:0] hi_u);
    logic signed [32:0] du, dv, dd;
    logic [65:0]        num, den, quo, rem;
    du = 33'(hi_u) - 33'(lo_u);
    dv = 33'(v) - 33'(lo_d);
    dd = 33'(hi_d) - 33'(lo_d);
    num = 66'($unsigned(du < 0 ? -du : du)) * 66'($unsigned(dv));
    den = 66'($unsigned(dd));
    quo = num / den;
    rem = num % den;
    if (2 * rem >= den) quo = quo + 1;
    return (du < 0) ? lo_u - quo[31:0] : lo_u + quo[31:0];
  endfunction

  task automatic map_step(input plam_pkg::in_beat_t b, output plam_pkg::out_beat_t r);
    int a, n, i, k;
    a = b.axis;
    n = key_cnt[a];
    r.result_value = '0;
    r.status = plam_pkg::ST_DONE;
    i = 0;
    while (i < n && key_tab[a][i] < b.design_value) i++;
    case (b.kind)
      plam_pkg::KIND_QUERY: begin
        if (!map_on) begin
          r.result_value = b.design_value;
          r.status = plam_pkg::ST_UNLOADED;
        end else if (n == 0) begin
          r.result_value = b.design_value;
          r.status = plam_pkg::ST_EMPTY;
        end else if (i == n) begin
          r.result_value = lim_hi[a];
          r.status = plam_pkg::ST_PIN_MAX;
        end else if (key_tab[a][i] == b.design_value) begin
          r.result_value = user_tab[a][i];
          r.status = plam_pkg::ST_MAPPED;
        end else if (i == 0) begin
          r.result_value = lim_lo[a];
          r.status = plam_pkg::ST_PIN_MIN;
        end else begin
          r.result_value = lerp(b.design_value, key_tab[a][i-1], user_tab[a][i-1],
                                key_tab[a][i], user_tab[a][i]);
          r.status = plam_pkg::ST_MAPPED;
        end
      end
      plam_pkg::KIND_INSERT: begin
        if (i < n && key_tab[a][i] == b.design_value) begin
          r.status = plam_pkg::ST_DUP;   // checked ahead of the full test
        end else if (n >= POINTS) begin
          r.status = plam_pkg::ST_FULL;
        end else begin
          for (k = n; k > i; k--) begin
            key_tab[a][k]  = key_tab[a][k-1];
            user_tab[a][k] = user_tab[a][k-1];
          end
          key_tab[a][i]  = b.design_value;
          user_tab[a][i] = b.user_value;
          key_cnt[a] = n + 1;
        end
      end
      plam_pkg::KIND_LIMITS: begin
        // stored as given, min/max order not checked
        lim_lo[a] = b.limit_min;
        lim_hi[a] = b.limit_max;
      end
      default: key_cnt[a] = 0;  // clear keeps the limits
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Directed table: a row is either a map_enable write or a command beat,
  // with an expected result typed in where it is obvious.
  // ---------------------------------------------------------------------
  typedef struct {
    bit                 is_cfg;
    bit                 en;
    plam_pkg::in_beat_t b;
    bit                 typed;
    logic signed [31:0] val;
    logic [2:0]         st;
  } row_t;

  row_t rows[$];

  function automatic void add_row(input row_t r);
    rows = {rows, r};
  endfunction

  function automatic row_t cmd(logic [1:0] kind, logic [1:0] axis,
      logic [31:0] dv, logic [31:0] uv, logic [31:0] lmin, logic [31:0] lmax,
      bit typed = 0, logic [31:0] val = 0, logic [2:0] st = plam_pkg::ST_DONE);
    row_t r;
    r.is_cfg = 0;
    r.en = 0;
    r.b.kind = kind;
    r.b.axis = axis;
    r.b.design_value = dv;
    r.b.user_value = uv;
    r.b.limit_min = lmin;
    r.b.limit_max = lmax;
    r.typed = typed;
    r.val = val;
    r.st = st;
    return r;
  endfunction

  function automatic row_t cfg_row(bit en);
    row_t r;
    r = cmd(plam_pkg::KIND_QUERY, 0, 0, 0, 0, 0);
    r.is_cfg = 1;
    r.en = en;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------
  bit no_gaps = 0;

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_enable(input bit en);
    in_valid <= 1'b0;
    drain();
    repeat (4) @(posedge clk);
    map_enable_we <= 1'b1;
    map_enable_wdata <= en;
    @(posedge clk);
    map_enable_we <= 1'b0;
    map_on = en;
  endtask

  // Drive one beat and hold it until accepted; the predictor runs at accept.
  task automatic send_beat(input plam_pkg::in_beat_t b, input bit typed,
      input logic signed [31:0] val, input logic [2:0] st);
    int                  gap;
    plam_pkg::out_beat_t r;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    map_step(b, r);
    if (typed) begin
      r.result_value = val;
      r.status = st;
    end
    pending_results = {pending_results, r};
  endtask

  function automatic logic [31:0] grid_value();
    return 32'((int'($urandom_range(0, 48)) - 24) * 16384);
  endfunction

  // Mostly keys on a coarse grid so duplicates and full tables occur,
  // plus full-range values so every bit toggles.
  function automatic plam_pkg::in_beat_t random_cmd();
    plam_pkg::in_beat_t b;
    int                 pick, a;
    b.axis = 2'($urandom_range(0, 3));
    a = b.axis;
    b.user_value = $urandom;
    b.limit_min = $urandom;
    b.limit_max = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 55)      b.kind = plam_pkg::KIND_QUERY;
    else if (pick < 88) b.kind = plam_pkg::KIND_INSERT;
    else if (pick < 96) b.kind = plam_pkg::KIND_LIMITS;
    else                b.kind = plam_pkg::KIND_CLEAR;
    pick = $urandom_range(0, 9);
    if (b.kind == plam_pkg::KIND_QUERY && pick < 3 && key_cnt[a] > 0)
      b.design_value = key_tab[a][$urandom_range(0, key_cnt[a] - 1)];
    else if (pick < 8)
      b.design_value = grid_value() +
                       ((b.kind == plam_pkg::KIND_QUERY) ? $urandom_range(0, 16383) : 0);
    else
      b.design_value = $urandom;
    return b;
  endfunction

  initial begin
    int                 left, len;
    plam_pkg::in_beat_t b;

    for (int a = 0; a < AXES; a++) begin
      key_cnt[a] = 0;
      lim_lo[a] = 0;
      lim_hi[a] = 0;
    end
    map_on = 0;

    // unloaded passthrough at both extremes
    add_row(cmd(plam_pkg::KIND_QUERY, 0, 32'h7fffffff, 0, 0, 0, 1, 32'h7fffffff,
                plam_pkg::ST_UNLOADED));
    add_row(cmd(plam_pkg::KIND_QUERY, 3, 32'h80000000, 0, 0, 0, 1, 32'h80000000,
                plam_pkg::ST_UNLOADED));
    add_row(cfg_row(1));
    // empty table passthrough
    add_row(cmd(plam_pkg::KIND_QUERY, 1, 32'h00000005, 0, 0, 0, 1, 32'h00000005,
                plam_pkg::ST_EMPTY));
    add_row(cmd(plam_pkg::KIND_LIMITS, 0, 0, 0, 32'h80000000, 32'h7fffffff, 1, 0,
                plam_pkg::ST_DONE));
    add_row(cmd(plam_pkg::KIND_INSERT, 0, 32'h00000000, 32'h00000000, 0, 0, 1, 0,
                plam_pkg::ST_DONE));
    add_row(cmd(plam_pkg::KIND_INSERT, 0, 32'h00010000, 32'h7fffffff, 0, 0, 1, 0,
                plam_pkg::ST_DONE));
    add_row(cmd(plam_pkg::KIND_INSERT, 0, 32'h00000000, 32'h12345678, 0, 0, 1, 0,
                plam_pkg::ST_DUP));
    add_row(cmd(plam_pkg::KIND_QUERY, 0, 32'h00000000, 0, 0, 0, 1, 0, plam_pkg::ST_MAPPED));
    add_row(cmd(plam_pkg::KIND_QUERY, 0, 32'h00008000, 0, 0, 0));
    add_row(cmd(plam_pkg::KIND_QUERY, 0, 32'h7fffffff, 0, 0, 0, 1, 32'h7fffffff,
                plam_pkg::ST_PIN_MAX));
    add_row(cmd(plam_pkg::KIND_QUERY, 0, 32'h80000000, 0, 0, 0, 1, 32'h80000000,
                plam_pkg::ST_PIN_MIN));
    // widest spans: keys and user values at the extremes
    add_row(cmd(plam_pkg::KIND_INSERT, 0, 32'h80000000, 32'h80000000, 0, 0, 1, 0,
                plam_pkg::ST_DONE));
    add_row(cmd(plam_pkg::KIND_INSERT, 0, 32'h7fffffff, 32'h80000001, 0, 0, 1, 0,
                plam_pkg::ST_DONE));
    add_row(cmd(plam_pkg::KIND_QUERY, 0, 32'hffffffff, 0, 0, 0));
    add_row(cmd(plam_pkg::KIND_QUERY, 0, 32'h7ffffffe, 0, 0, 0));
    add_row(cmd(plam_pkg::KIND_QUERY, 0, 32'h80000001, 0, 0, 0));
    // unordered limits accepted as given
    add_row(cmd(plam_pkg::KIND_LIMITS, 2, 0, 0, 32'h00000005, 32'hfffffffb, 1, 0,
                plam_pkg::ST_DONE));
    add_row(cmd(plam_pkg::KIND_INSERT, 2, 32'h00020000, 32'h00030000, 0, 0));
    add_row(cmd(plam_pkg::KIND_QUERY, 2, 32'h00030000, 0, 0, 0, 1, 32'hfffffffb,
                plam_pkg::ST_PIN_MAX));
    add_row(cmd(plam_pkg::KIND_QUERY, 2, 32'h00010000, 0, 0, 0, 1, 32'h00000005,
                plam_pkg::ST_PIN_MIN));
    // clear drops the keys only
    add_row(cmd(plam_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 1, 0, plam_pkg::ST_DONE));
    add_row(cmd(plam_pkg::KIND_QUERY, 0, 32'h00001234, 0, 0, 0, 1, 32'h00001234,
                plam_pkg::ST_EMPTY));
    add_row(cfg_row(0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_enable(rows[i].en);
      else send_beat(rows[i].b, rows[i].typed, rows[i].val, rows[i].st);
    end

    // Fill one axis past capacity: sixteen inserts, then a full and a duplicate.
    write_enable(1);
    for (int k = 0; k <= POINTS; k++) begin
      b = '0;
      b.kind = plam_pkg::KIND_INSERT;
      b.axis = 3;
      b.design_value = 32'(k * 65536);
      b.user_value = 32'(k * 3000);
      send_beat(b, k == POINTS, 0, plam_pkg::ST_FULL);
    end
    b.design_value = 32'h00050000;
    send_beat(b, 1, 0, plam_pkg::ST_DUP);

    // Random phases; each opens with the sender held off until all results are in.
    left = RAND_ITEMS;
    while (left > 0) begin
      write_enable($urandom_range(0, 5) != 0);
      no_gaps = ($urandom_range(0, 3) == 0);
      len = $urandom_range(40, 160);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) send_beat(random_cmd(), 0, 0, plam_pkg::ST_DONE);
      left -= len;
    end

    in_valid <= 1'b0;
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver side: random stall per result beat, checking, watchdog
  // ---------------------------------------------------------------------
  int wait_left = 0;
  bit fast_rx = 0;
  int quiet_cycles = 0;

  always @(posedge clk) begin
    plam_pkg::out_beat_t want;
    bit                  took;
    took = 0;
    if (!rst) begin
      if (in_valid && !in_stall) took = 1;
      if (out_valid && !out_stall) begin
        took = 1;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat value=%h status=%0d", $time,
                   out_item.result_value, out_item.status);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_item.result_value !== want.result_value) begin
            $display("%0t: result_value expected %h actual %h", $time,
                     want.result_value, out_item.result_value);
            errors++;
          end
          if (out_item.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_item.status);
            errors++;
          end
        end
        if ($urandom_range(0, 63) == 0) fast_rx = !fast_rx;
        wait_left = fast_rx ? 0 : $urandom_range(0, 18);
      end else if (wait_left > 0) begin
        wait_left--;
      end
      out_stall <= (wait_left != 0);

      quiet_cycles = took ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule

/* filelist.f */
rtl/plam_pkg.sv
rtl/plam_ram.sv
rtl/piecewise_linear_axis_map.sv
rtl/plam_checker.sv
dv/testbench.sv
